// File: src/atpag_pkg.sv
// Package with the constants, codes and lane swizzle of the attention tile pack address generator.
package atpag_pkg;

    // Head geometry and row field size.
    localparam int HEAD_DIM        = 72;
    localparam int PADDED_HEAD_DIM = 80;
    localparam int KEY_BLOCK_ROWS  = 16;
    localparam int ROW_FIELD_BITS  = 10;

    // Number of 16-column panels in the padded head and of 16-row key groups.
    localparam int PANELS  = PADDED_HEAD_DIM / 16;
    localparam int KGROUPS = KEY_BLOCK_ROWS / 16;

    // Bits of a row start register that are kept.
    localparam logic [9:0] ROW_MASK = (ROW_FIELD_BITS >= 10) ? 10'h3FF
                                    : 10'((1 << ROW_FIELD_BITS) - 1);

    // Port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    typedef enum logic [1:0] {
        LAYOUT_QUERY = 2'd0,
        LAYOUT_KEY   = 2'd1,
        LAYOUT_VALUE = 2'd2
    } layout_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LAYOUT_KIND      = 3'd0,
        REG_SOURCE_ROWS      = 3'd1,
        REG_HEAD_START       = 3'd2,
        REG_SOURCE_ROW_START = 3'd3,
        REG_DEST_ROW_START   = 3'd4,
        REG_COPY_ROWS        = 3'd5,
        REG_DEST_ROWS        = 3'd6
    } cfg_reg_t;

    // Pair swizzle within a group of 16: pairs 0..3 interleave with pairs 4..7.
    function automatic logic [3:0] swizzle_lane(input logic [3:0] x);
        logic [2:0] pair;
        pair = x[3:1];
        return {pair[1:0], pair[2], x[0]};
    endfunction

endpackage

// File: src/attention_tile_pack_address_gen.sv
// Top level of the attention tile pack address generator.
//
// The block turns one element position (local_row, head_column) into a source
// read index, a destination write index, a zero-fill flag and a write enable
// for a relayout copy engine. A request is taken at every rising edge where
// start is high; busy is always low, so a new request may be issued in every
// cycle and the block sustains one address per clock. Each result is shown
// for exactly one cycle, marked by done; the receiver cannot stall, so it
// must take the result in that cycle. The request is registered first; from
// the request register all indices are formed with two small multipliers
// (column panel times source rows, and panel times destination rows)
// followed by an add, and registered as the result. When write_enable is
// low, source_index, dest_index and zero_fill are all zero; when zero_fill is
// high, source_index is zero. Configuration registers are written through
// cfg_write, cfg_index and cfg_data, and must only be written while no request
// is in flight; a write to an index outside the register list is ignored.
module attention_tile_pack_address_gen
    import atpag_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   start,
    output logic                   busy,
    input  logic [9:0]             local_row,
    input  logic [6:0]             head_column,

    output logic                   done,
    output logic [21:0]            source_index,
    output logic [17:0]            dest_index,
    output logic                   zero_fill,
    output logic                   write_enable
);

    // Configuration registers.
    logic [1:0]  layout_kind_reg;
    logic [10:0] source_rows_reg;
    logic [9:0]  head_start_reg;
    logic [9:0]  source_row_start_reg;
    logic [9:0]  dest_row_start_reg;
    logic [10:0] copy_rows_reg;
    logic [10:0] dest_rows_reg;

    // Request register.
    logic        req_valid_reg;
    logic [9:0]  local_row_reg;
    logic [6:0]  head_column_reg;

    // Result register.
    logic        done_reg;
    logic [21:0] source_index_reg;
    logic [17:0] dest_index_reg;
    logic        zero_fill_reg;
    logic        write_enable_reg;

    logic [21:0] source_index_next;
    logic [17:0] dest_index_next;
    logic        zero_fill_next;
    logic        write_enable_next;

    // Intermediate address terms.
    logic [10:0] col_sum;
    logic [10:0] src_row_sum;
    logic [10:0] dst_row_sum;
    logic [2:0]  panel;
    logic [3:0]  col_in;
    logic [6:0]  dst_group;
    logic [17:0] src_prod;
    logic [21:0] src_addr;
    logic [13:0] query_prod;
    logic [17:0] query_addr;
    logic [9:0]  key_block;
    logic [17:0] key_addr;
    logic [9:0]  value_block;
    logic [17:0] value_addr;
    logic        group_past_head;
    logic        col_past_head;
    logic        base_we;

    assign busy = 1'b0;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_kind_reg      <= '0;
            source_rows_reg      <= '0;
            head_start_reg       <= '0;
            source_row_start_reg <= '0;
            dest_row_start_reg   <= '0;
            copy_rows_reg        <= '0;
            dest_rows_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LAYOUT_KIND:      layout_kind_reg      <= cfg_data[1:0];
                REG_SOURCE_ROWS:      source_rows_reg      <= cfg_data;
                REG_HEAD_START:       head_start_reg       <= cfg_data[9:0];
                REG_SOURCE_ROW_START: source_row_start_reg <= cfg_data[9:0] & ROW_MASK;
                REG_DEST_ROW_START:   dest_row_start_reg   <= cfg_data[9:0] & ROW_MASK;
                REG_COPY_ROWS:        copy_rows_reg        <= cfg_data;
                REG_DEST_ROWS:        dest_rows_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Request register: a new request is taken in every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            local_row_reg   <= local_row;
            head_column_reg <= head_column;
        end
    end

    // Address terms: those shared by all layouts, and each layout's address.
    always_comb
    begin
        col_sum     = {1'b0, head_start_reg} + {4'b0, head_column_reg};
        src_row_sum = {1'b0, source_row_start_reg} + {1'b0, local_row_reg};
        dst_row_sum = {1'b0, dest_row_start_reg} + {1'b0, local_row_reg};
        panel       = head_column_reg[6:4];
        col_in      = head_column_reg[3:0];
        dst_group   = dst_row_sum[10:4];

        // Source: 16-column panels, each source_rows tall.
        src_prod = 18'(col_sum[10:4]) * 18'(source_rows_reg);
        src_addr = {src_prod, 4'b0} + {7'b0, src_row_sum, 4'b0} + 22'(col_sum[3:0]);

        // Query: row-major 16-wide panels, dest_rows tall.
        query_prod = 14'(panel) * 14'(dest_rows_reg);
        query_addr = {query_prod, 4'b0} + {3'b0, dst_row_sum, 4'b0} + 18'(col_in);

        // Key: one 256-element block per row group and column panel, rows swizzled.
        // Only the low ten bits of the block number reach the 18-bit index.
        key_block = 10'(dst_group) * 10'(PANELS) + 10'(panel);
        key_addr  = {key_block, 8'b0} + {10'b0, swizzle_lane(dst_row_sum[3:0]), 4'b0}
                  + 18'(col_in);

        // Value: one block per column panel and key group, columns swizzled.
        value_block = 10'(panel) * 10'(KGROUPS) + 10'(dst_group);
        value_addr  = {value_block, 8'b0} + {10'b0, swizzle_lane(col_in), 4'b0}
                    + 18'(dst_row_sum[3:0]);

        // Query and key pad in aligned groups of four columns; value per column.
        group_past_head = !(({2'b0, head_column_reg[6:2], 2'b0} + 9'd3) < 9'(HEAD_DIM));
        col_past_head   = !({2'b0, head_column_reg} < 9'(HEAD_DIM));

        base_we = ({1'b0, local_row_reg} < copy_rows_reg) && (5'(panel) < 5'(PANELS));
    end

    // Layout selection and masking of unwritten elements.
    always_comb
    begin
        write_enable_next = base_we;
        zero_fill_next    = 1'b0;
        dest_index_next   = '0;

        unique case (layout_t'(layout_kind_reg))
            LAYOUT_QUERY:
            begin
                zero_fill_next  = group_past_head;
                dest_index_next = query_addr;
            end
            LAYOUT_KEY:
            begin
                // Rows past the key block are not written.
                write_enable_next = base_we && (dst_group < 7'(KGROUPS));
                zero_fill_next    = group_past_head;
                dest_index_next   = key_addr;
            end
            LAYOUT_VALUE:
            begin
                zero_fill_next  = col_past_head;
                dest_index_next = value_addr;
            end
            default:
            begin
                write_enable_next = 1'b0;
            end
        endcase

        source_index_next = (zero_fill_next || !write_enable_next) ? '0 : src_addr;
        if (!write_enable_next)
        begin
            zero_fill_next  = 1'b0;
            dest_index_next = '0;
        end
    end

    // Result register: each result is shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            source_index_reg <= source_index_next;
            dest_index_reg   <= dest_index_next;
            zero_fill_reg    <= zero_fill_next;
            write_enable_reg <= write_enable_next;
        end
    end

    assign done         = done_reg;
    assign source_index = source_index_reg;
    assign dest_index   = dest_index_reg;
    assign zero_fill    = zero_fill_reg;
    assign write_enable = write_enable_reg;

    // Every request yields exactly one result, through the request and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("request did not produce a result two cycles later");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_valid_reg))
        else $error("result strobe without a registered request");

    // An element that is not written carries no addresses and no fill flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !write_enable |-> source_index == '0 && dest_index == '0 && !zero_fill)
        else $error("unwritten element carries nonzero fields");

    // A zero-filled element never reads the source.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_fill |-> source_index == '0 && write_enable)
        else $error("zero-filled element has a source index");

endmodule

// File: sim/attention_tile_pack_address_gen_tb.sv
// Self-checking testbench for the attention tile pack address generator.
`timescale 1ns / 100ps

module attention_tile_pack_address_gen_tb
    import atpag_pkg::*;
();

    // The fourth layout code has no member in the package; the block must
    // suppress the write for it.
    localparam logic [1:0] LAYOUT_UNUSED = 2'd3;

    // A run fails when this many cycles pass with no request, no result and
    // no register write. Idle gaps ahead of a request are short on average and
    // each result comes through the request and result registers, so this is generous.
    localparam int STALL_LIMIT   = 1000;
    // Cycles to wait after the last expected result before judging the run.
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [21:0] source_index;
        logic [17:0] dest_index;
        logic        zero_fill;
        logic        write_enable;
    } pack_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   start;
    logic                   busy;
    logic [9:0]             local_row;
    logic [6:0]             head_column;
    logic                   done;
    logic [21:0]            source_index;
    logic [17:0]            dest_index;
    logic                   zero_fill;
    logic                   write_enable;

    // Mirror of the block's configuration registers, updated as they are written.
    logic [1:0]  m_layout;
    logic [10:0] m_source_rows;
    logic [9:0]  m_head_start;
    logic [9:0]  m_src_row_start;
    logic [9:0]  m_dest_row_start;
    logic [10:0] m_copy_rows;
    logic [10:0] m_dest_rows;

    // Addresses predicted for accepted requests, oldest first.
    pack_result_t pending_addresses[$];

    bit gaps_on;
    int fail_count;
    int n_requests;
    int n_results;
    int n_written;
    int n_zero_filled;
    int n_suppressed;
    int n_settings;
    int quiet_cycles;

    attention_tile_pack_address_gen dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .local_row    (local_row),
        .head_column  (head_column),
        .done         (done),
        .source_index (source_index),
        .dest_index   (dest_index),
        .zero_fill    (zero_fill),
        .write_enable (write_enable)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Lane order inside a 16-wide group: the eight pairs are reordered so that
    // pairs 0..3 land on even pair slots and pairs 4..7 on odd ones.
    function automatic int unsigned pair_swizzle(input logic [3:0] x);
        int unsigned pair;
        int unsigned slot;
        pair = x[3:1];
        slot = (pair % 4) * 2 + pair / 4;
        return slot * 2 + x[0];
    endfunction

    // Works out the read index, write index and flags for one element position
    // under the current register mirror.
    function automatic pack_result_t predict_pack_address(input logic [9:0] lr,
                                                          input logic [6:0] hc);
        int unsigned d;
        int unsigned r;
        int unsigned c;
        int unsigned panel;
        int unsigned colin;
        int unsigned dst;
        int unsigned src;
        logic        we;
        logic        zf;
        pack_result_t res;
        d     = m_dest_row_start + lr;
        r     = m_src_row_start + lr;
        c     = m_head_start + hc;
        panel = hc / 16;
        colin = hc % 16;
        we    = (lr < m_copy_rows) && (panel < PANELS);
        zf    = 1'b0;
        dst   = 0;
        case (m_layout)
            LAYOUT_QUERY:
            begin
                // Query and key test whole groups of four columns.
                zf  = ((hc & 7'h7C) + 3) >= HEAD_DIM;
                dst = panel * m_dest_rows * 16 + d * 16 + colin;
            end
            LAYOUT_KEY:
            begin
                if (d / 16 >= KGROUPS)
                    we = 1'b0;
                zf  = ((hc & 7'h7C) + 3) >= HEAD_DIM;
                dst = ((d / 16) * PANELS + panel) * 256
                      + pair_swizzle(4'(d % 16)) * 16 + colin;
            end
            LAYOUT_VALUE:
            begin
                zf  = hc >= HEAD_DIM;
                dst = (panel * KGROUPS + d / 16) * 256
                      + pair_swizzle(4'(colin)) * 16 + d % 16;
            end
            default:
                we = 1'b0;
        endcase
        src = (c / 16) * m_source_rows * 16 + r * 16 + c % 16;
        res.write_enable = we;
        res.zero_fill    = we & zf;
        res.dest_index   = we ? 18'(dst) : '0;
        res.source_index = (we && !zf) ? 22'(src) : '0;
        return res;
    endfunction

    // Result checker. The receiver cannot stall, so every done cycle is a
    // result that must match the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_addresses.size() == 0)
            begin
                $error("result with no request outstanding: src %0d dst %0d",
                       source_index, dest_index);
                fail_count++;
            end
            else
            begin
                pack_result_t exp_r;
                exp_r = pending_addresses.pop_front();
                if (source_index !== exp_r.source_index)
                begin
                    $error("source_index: expected %0d, got %0d",
                           exp_r.source_index, source_index);
                    fail_count++;
                end
                if (dest_index !== exp_r.dest_index)
                begin
                    $error("dest_index: expected %0d, got %0d",
                           exp_r.dest_index, dest_index);
                    fail_count++;
                end
                if (zero_fill !== exp_r.zero_fill)
                begin
                    $error("zero_fill: expected %0d, got %0d",
                           exp_r.zero_fill, zero_fill);
                    fail_count++;
                end
                if (write_enable !== exp_r.write_enable)
                begin
                    $error("write_enable: expected %0d, got %0d",
                           exp_r.write_enable, write_enable);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any request, result or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Issues one request, with random idle cycles ahead of it when gaps are on.
    // Start is left high on return so back-to-back requests need no toggling.
    task automatic send_request(input logic [9:0] lr, input logic [6:0] hc);
        pack_result_t exp_r;
        while (gaps_on && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        local_row   <= lr;
        head_column <= hc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        exp_r = predict_pack_address(lr, hc);
        pending_addresses.push_back(exp_r);
        n_requests++;
        if (!exp_r.write_enable)
            n_suppressed++;
        else if (exp_r.zero_fill)
            n_zero_filled++;
        else
            n_written++;
    endtask

    // Drops start and waits until every predicted result has come back.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_addresses.size() != 0)
            @(posedge clk);
    endtask

    // One register write; cfg_write stays high so that writes can follow
    // each other on consecutive edges.
    task automatic write_register(input cfg_reg_t idx, input logic [10:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_LAYOUT_KIND:      m_layout         = val[1:0];
            REG_SOURCE_ROWS:      m_source_rows    = val;
            REG_HEAD_START:       m_head_start     = val[9:0];
            REG_SOURCE_ROW_START: m_src_row_start  = val[9:0] & ROW_MASK;
            REG_DEST_ROW_START:   m_dest_row_start = val[9:0] & ROW_MASK;
            REG_COPY_ROWS:        m_copy_rows      = val;
            REG_DEST_ROWS:        m_dest_rows      = val;
            default:              ;
        endcase
    endtask

    // Waits for the block to go idle, then rewrites every register.
    task automatic apply_settings(input logic [1:0] layout, input int unsigned srows,
                                  input int unsigned hstart, input int unsigned srs,
                                  input int unsigned drs, input int unsigned crows,
                                  input int unsigned drows);
        wait_idle();
        write_register(REG_LAYOUT_KIND, 11'(layout));
        write_register(REG_SOURCE_ROWS, 11'(srows));
        write_register(REG_HEAD_START, 11'(hstart));
        write_register(REG_SOURCE_ROW_START, 11'(srs));
        write_register(REG_DEST_ROW_START, 11'(drs));
        write_register(REG_COPY_ROWS, 11'(crows));
        write_register(REG_DEST_ROWS, 11'(drows));
        cfg_write <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // Picks a register value, with both ends of its range favored.
    function automatic int unsigned pick_value(input int unsigned max_v);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return max_v;
        return $urandom_range(0, max_v);
    endfunction

    // Straight out of reset all registers are zero, so copy_rows is zero and
    // nothing may be written.
    task automatic test_reset_defaults();
        send_request(10'd0, 7'd0);
        send_request(10'd1023, 7'd79);
    endtask

    // Query panels with start registers at top value and row counts at 1024, the
    // zero-fill group boundary, columns past the padded head and the copy pass end.
    task automatic test_query_layout();
        apply_settings(LAYOUT_QUERY, 1024, 1023, 1023, 1023, 1024, 1024);
        send_request(10'd0, 7'd0);
        send_request(10'd1023, 7'd79);
        send_request(10'd5, 7'd67);
        send_request(10'd5, 7'd68);
        send_request(10'd5, 7'd72);
        send_request(10'd7, 7'd80);
        send_request(10'd9, 7'd127);
        apply_settings(LAYOUT_QUERY, 0, 0, 0, 0, 10, 0);
        send_request(10'd9, 7'd3);
        send_request(10'd10, 7'd3);
    endtask

    // Key blocks: the swizzled row lanes, and rows past the single key block.
    task automatic test_key_layout();
        apply_settings(LAYOUT_KEY, 64, 0, 0, 0, 1024, 0);
        send_request(10'd0, 7'd0);
        send_request(10'd15, 7'd79);
        send_request(10'd6, 7'd33);
        send_request(10'd16, 7'd5);
        apply_settings(LAYOUT_KEY, 300, 17, 40, 14, 1024, 0);
        send_request(10'd1, 7'd20);
        send_request(10'd2, 7'd20);
    endtask

    // Value blocks: per-column zero fill and the swizzled column lanes.
    task automatic test_value_layout();
        apply_settings(LAYOUT_VALUE, 128, 5, 3, 5, 1024, 0);
        send_request(10'd0, 7'd71);
        send_request(10'd3, 7'd72);
        send_request(10'd10, 7'd15);
        send_request(10'd1023, 7'd64);
    endtask

    // The layout code with no meaning suppresses every write.
    task automatic test_unknown_layout();
        apply_settings(LAYOUT_UNUSED, 16, 0, 0, 0, 1024, 16);
        send_request(10'd0, 7'd0);
    endtask

    // Random settings, twelve phases of fifty requests. Rows are mostly kept
    // inside the copy pass, and for key layout inside the key block, so that
    // most requests produce real addresses. Two phases run with no gaps.
    task automatic test_random_traffic();
        logic [1:0]  layout;
        int unsigned srows;
        int unsigned hstart;
        int unsigned srs;
        int unsigned drs;
        int unsigned crows;
        int unsigned drows;
        logic [9:0]  lr;
        logic [6:0]  hc;
        for (int phase = 0; phase < 12; phase++)
        begin
            layout = ($urandom_range(0, 11) == 0) ? LAYOUT_UNUSED
                                                  : 2'($urandom_range(0, 2));
            srows  = pick_value(1024);
            hstart = pick_value(1023);
            srs    = pick_value(1023);
            if (layout == LAYOUT_KEY && $urandom_range(0, 3) != 0)
                drs = $urandom_range(0, 15);
            else
                drs = pick_value(1023);
            crows  = pick_value(1024);
            drows  = pick_value(1024);
            gaps_on = !(phase == 4 || phase == 5);
            apply_settings(layout, srows, hstart, srs, drs, crows, drows);
            repeat (50)
            begin
                if (layout == LAYOUT_KEY && drs < 16 && $urandom_range(0, 3) != 0)
                    lr = 10'($urandom_range(0, 15 - drs));
                else if (crows != 0 && $urandom_range(0, 4) != 0)
                    lr = 10'($urandom_range(0, crows - 1));
                else
                    lr = 10'($urandom_range(0, 1023));
                if ($urandom_range(0, 9) == 0)
                    hc = 7'($urandom_range(0, 127));
                else
                    hc = 7'($urandom_range(0, 79));
                send_request(lr, hc);
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_LAYOUT_KIND;
        cfg_data    <= '0;
        start       <= 1'b0;
        local_row   <= '0;
        head_column <= '0;
        gaps_on      = 1'b1;
        m_layout         = LAYOUT_QUERY;
        m_source_rows    = '0;
        m_head_start     = '0;
        m_src_row_start  = '0;
        m_dest_row_start = '0;
        m_copy_rows      = '0;
        m_dest_rows      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_query_layout();
        test_key_layout();
        test_value_layout();
        test_unknown_layout();
        test_random_traffic();

        // Drain, then give the pipeline time to show any stray result.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_addresses.size() != 0)
        begin
            $error("%0d results never arrived", pending_addresses.size());
            fail_count++;
        end

        $display("Run covered %0d requests under %0d register settings, %0d results seen.",
                 n_requests, n_settings, n_results);
        $display("Addresses: %0d data writes, %0d zero fills, %0d suppressed writes.",
                 n_written, n_zero_filled, n_suppressed);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
src/atpag_pkg.sv
src/attention_tile_pack_address_gen.sv
sim/attention_tile_pack_address_gen_tb.sv
